/* rtl/terr_pkg.sv */
// Shared types and constants for the tile error region refiner.
// Holds the sequencer state type, operation codes and register indexes.
// Depends on nothing; used by the top level.
package terr_pkg;

	// Error value that stands for infinity.
	localparam logic [31:0] ERR_INF = 32'hFFFF_FFFF;

	// Register indexes on the configuration port (paddr bit 2).
	localparam logic REG_GRID_W = 1'b0;
	localparam logic REG_GRID_H = 1'b1;

	// Operation codes of an input transaction.
	typedef enum logic [1:0] {
		FN_UPDATE = 2'd0,
		FN_READ   = 2'd1,
		FN_REFINE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD_WAIT,
		ST_F_ISSUE,
		ST_F_USE,
		ST_F_END,
		ST_POST,
		ST_DIV,
		ST_R_CHECK,
		ST_R_LOAD,
		ST_R_LWAIT,
		ST_S_ISSUE,
		ST_S_USE,
		ST_RAISE_ISSUE,
		ST_RAISE_USE,
		ST_MEAN,
		ST_DECIDE,
		ST_RM_RD_A,
		ST_RM_RD_B,
		ST_RM_WR_A,
		ST_RM_WR_B,
		ST_SPLIT_A,
		ST_SPLIT_B,
		ST_DONE
	} state_t;

endpackage

/* rtl/terr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module terr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/tile_error_region_refiner.sv */
// Top level of the tile error region refiner: error store, region list and sequencer.
// Depends on terr_pkg (types, constants) and terr_ram (error and region memories).
//
// Usage: input transactions (func, tile_col, tile_row, error_value, threshold) are
// taken on in_valid while in_stall is low; each yields one output transaction
// (tile_error, frame_error, region_total) on out_valid, held while out_stall is high.
// The block works on one transaction at a time; in_stall is high until it is done,
// and a finished result may wait in the output register while the next one is taken.
// An update writes its tile's entry when taken, a read waits for the registered read port,
// and a clear runs the clearing pass below. A refine scans every tile of the grid and runs
// the frame mean divide when it is needed. Then each visited region is loaded, its tiles
// are scanned (and raised when its maximum exceeds the threshold), its mean divide runs
// when needed, and a decision may split or remove it. The shared divider (one quotient
// bit per cycle) and the single read port of each memory pace these steps.
// Reset, and every write to grid_width or grid_height, starts a pass that writes
// infinity into all DEPTH error entries, one per cycle, and rebuilds region 0;
// no transaction is taken until it ends. Configuration uses an APB-style port with
// pready tied high. When the receiver stalls, the result stays put in the output
// register and the block holds its next result until that one is taken.
module tile_error_region_refiner #(
	parameter int MAX_TILES_X = 16,
	parameter int MAX_TILES_Y = 16,
	parameter int MAX_REGIONS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  tile_col,
	input  logic [3:0]  tile_row,
	input  logic [31:0] error_value,
	input  logic [31:0] threshold,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] tile_error,
	output logic [31:0] frame_error,
	output logic [8:0]  region_total
);

	localparam int DEPTH = MAX_TILES_X * MAX_TILES_Y;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int MAXXY = MAX_TILES_X > MAX_TILES_Y ? MAX_TILES_X : MAX_TILES_Y;
	localparam int CW    = $clog2(MAXXY + 1);
	localparam int PW    = 2 * CW;
	localparam int RW    = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;
	localparam int CNTW  = $clog2(MAX_REGIONS + 1);
	localparam int RGW   = 4 * CW;

	terr_pkg::state_t state_q, state_d;

	logic [4:0]      gw_q, gh_q;
	logic [AW-1:0]   sweep_q;
	logic            reply_q;
	logic [31:0]     thr_q, min_err_q, lim4_q;
	logic [31:0]     maxv_q, sum_q;
	logic [PW-1:0]   act_q, ti_q, area_q;
	logic [CNTW-1:0] i_q, regions_q, count_q;
	logic [CW-1:0]   lx_q, ly_q, ux_q, uy_q, x_q, y_q;
	logic [31:0]     rmax_q, rsum_q, mean_q;
	logic [31:0]     div_rem_q, div_quo_q, div_den_q;
	logic [4:0]      div_cnt_q;
	logic            div_frame_q;
	logic [RGW-1:0]  rgn_a_q, rgn_b_q;
	logic [31:0]     res_tile_q, res_frame_q;
	logic            out_valid_q;
	logic [31:0]     tile_error_q, frame_error_q;
	logic [8:0]      region_total_q;

	// Memory ports.
	logic            err_we;
	logic [AW-1:0]   err_wa, err_ra;
	logic [31:0]     err_wd, err_rdata;
	logic            rgn_we;
	logic [RW-1:0]   rgn_wa, rgn_ra;
	logic [RGW-1:0]  rgn_wd, rgn_rdata;

	terr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_err_ram (
		.clk   (clk),
		.we    (err_we),
		.waddr (err_wa),
		.wdata (err_wd),
		.raddr (err_ra),
		.rdata (err_rdata)
	);

	terr_ram #(.WIDTH(RGW), .DEPTH(MAX_REGIONS)) u_rgn_ram (
		.clk   (clk),
		.we    (rgn_we),
		.waddr (rgn_wa),
		.wdata (rgn_wd),
		.raddr (rgn_ra),
		.rdata (rgn_rdata)
	);

	// Configuration port.
	logic cfg_we;
	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == terr_pkg::REG_GRID_H) ? {27'd0, gh_q} : {27'd0, gw_q};

	// Grid size in use, limited to the store.
	logic [CW-1:0] eff_w, eff_h;
	logic [PW-1:0] tiles;
	assign eff_w = (32'(gw_q) > MAX_TILES_X) ? CW'(MAX_TILES_X) : CW'(gw_q);
	assign eff_h = (32'(gh_q) > MAX_TILES_Y) ? CW'(MAX_TILES_Y) : CW'(gh_q);
	assign tiles = PW'(eff_w) * PW'(eff_h);

	// Input decoding.
	logic          in_acc, in_inside;
	logic [PW-1:0] in_idx, cur_idx;
	assign in_acc    = in_valid && (state_q == terr_pkg::ST_IDLE);
	assign in_inside = (32'(tile_col) < 32'(eff_w)) && (32'(tile_row) < 32'(eff_h));
	assign in_idx    = PW'(tile_row) * PW'(eff_w) + PW'(tile_col);
	assign cur_idx   = PW'(y_q) * PW'(eff_w) + PW'(x_q);
	assign in_stall  = (state_q != terr_pkg::ST_IDLE);

	// Threshold limits taken at accept.
	logic [33:0] thr4;
	logic [31:0] lim4_in, min_err_in;
	assign thr4       = {threshold, 2'b00};
	assign lim4_in    = (thr4 >= 34'h0_FFFF_FFFF) ? terr_pkg::ERR_INF : thr4[31:0];
	assign min_err_in = (threshold == terr_pkg::ERR_INF) ? terr_pkg::ERR_INF
		: threshold + 32'd1;

	// Saturating accumulators fed by the error memory.
	logic [32:0] fsum_w, rsum_w;
	logic [31:0] fsum_sat, rsum_sat, rmax_nx;
	assign fsum_w   = {1'b0, sum_q} + {1'b0, err_rdata};
	assign fsum_sat = (fsum_w >= 33'h0_FFFF_FFFF) ? terr_pkg::ERR_INF : fsum_w[31:0];
	assign rsum_w   = {1'b0, rsum_q} + {1'b0, err_rdata};
	assign rsum_sat = (rsum_w >= 33'h0_FFFF_FFFF) ? terr_pkg::ERR_INF : rsum_w[31:0];
	assign rmax_nx  = (err_rdata > rmax_q) ? err_rdata : rmax_q;

	// Region scan stepping.
	logic [CW-1:0] x_nx, y_nx;
	logic          x_end, scan_last;
	assign x_nx      = x_q + 1'b1;
	assign y_nx      = y_q + 1'b1;
	assign x_end     = (x_nx == ux_q);
	assign scan_last = x_end && (y_nx == uy_q);

	// Region loaded from memory.
	logic [CW-1:0] rd_lx, rd_ly, rd_ux, rd_uy;
	assign rd_lx = rgn_rdata[RGW-1 -: CW];
	assign rd_ly = rgn_rdata[3*CW-1 -: CW];
	assign rd_ux = rgn_rdata[2*CW-1 -: CW];
	assign rd_uy = rgn_rdata[CW-1:0];

	// Region size and split points.
	logic [CW-1:0] sx, sy, mid_x, mid_y;
	logic [PW-1:0] area_w;
	logic          split_x;
	assign sx      = (ux_q > lx_q) ? ux_q - lx_q : '0;
	assign sy      = (uy_q > ly_q) ? uy_q - ly_q : '0;
	assign area_w  = PW'(sx) * PW'(sy);
	assign mid_x   = lx_q + (sx >> 1);
	assign mid_y   = ly_q + (sy >> 1);
	assign split_x = (sx > sy);

	// One restoring divider step per cycle.
	logic [32:0] div_t, div_sub;
	logic        div_ge;
	logic [31:0] div_rem_nx, div_quo_nx;
	assign div_t      = {div_rem_q, div_quo_q[31]};
	assign div_sub    = div_t - {1'b0, div_den_q};
	assign div_ge     = (div_t >= {1'b0, div_den_q});
	assign div_rem_nx = div_ge ? div_sub[31:0] : div_t[31:0];
	assign div_quo_nx = {div_quo_q[30:0], div_ge};

	logic [CNTW-1:0] cnt_m1;
	assign cnt_m1 = count_q - 1'b1;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= terr_pkg::ST_SWEEP;
		end else if (cfg_we) begin
			state_q <= terr_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d = state_q;
		err_we  = 1'b0;
		err_wa  = cur_idx[AW-1:0];
		err_wd  = min_err_q;
		err_ra  = cur_idx[AW-1:0];
		rgn_we  = 1'b0;
		rgn_wa  = i_q[RW-1:0];
		rgn_wd  = rgn_a_q;
		rgn_ra  = i_q[RW-1:0];
		case (state_q)
			terr_pkg::ST_SWEEP: begin
				err_we = 1'b1;
				err_wa = sweep_q;
				err_wd = terr_pkg::ERR_INF;
				if (sweep_q == '0) begin
					rgn_we = 1'b1;
					rgn_wa = '0;
					rgn_wd = {CW'(0), CW'(0), eff_w, eff_h};
				end
				if (sweep_q == AW'(DEPTH - 1)) begin
					state_d = reply_q ? terr_pkg::ST_DONE : terr_pkg::ST_IDLE;
				end
			end
			terr_pkg::ST_IDLE: begin
				err_ra = in_idx[AW-1:0];
				if (in_acc) begin
					case (terr_pkg::func_t'(func))
						terr_pkg::FN_UPDATE: begin
							err_we  = in_inside;
							err_wa  = in_idx[AW-1:0];
							err_wd  = error_value;
							state_d = terr_pkg::ST_DONE;
						end
						terr_pkg::FN_READ: begin
							state_d = in_inside ? terr_pkg::ST_RD_WAIT : terr_pkg::ST_DONE;
						end
						terr_pkg::FN_REFINE: begin
							state_d = (tiles == '0) ? terr_pkg::ST_DONE : terr_pkg::ST_F_ISSUE;
						end
						default: begin
							state_d = terr_pkg::ST_SWEEP;
						end
					endcase
				end
			end
			terr_pkg::ST_RD_WAIT: state_d = terr_pkg::ST_DONE;
			terr_pkg::ST_F_ISSUE: begin
				err_ra  = ti_q[AW-1:0];
				state_d = terr_pkg::ST_F_USE;
			end
			terr_pkg::ST_F_USE: begin
				state_d = (ti_q + 1'b1 < tiles) ? terr_pkg::ST_F_ISSUE : terr_pkg::ST_F_END;
			end
			terr_pkg::ST_F_END: begin
				if ((act_q != '0) && (sum_q != terr_pkg::ERR_INF)) begin
					state_d = terr_pkg::ST_DIV;
				end else begin
					state_d = terr_pkg::ST_POST;
				end
			end
			terr_pkg::ST_POST: begin
				state_d = (thr_q != '0) ? terr_pkg::ST_R_CHECK : terr_pkg::ST_DONE;
			end
			terr_pkg::ST_DIV: begin
				if (div_cnt_q == 5'd31) begin
					state_d = div_frame_q ? terr_pkg::ST_POST : terr_pkg::ST_DECIDE;
				end
			end
			terr_pkg::ST_R_CHECK: begin
				state_d = (i_q < regions_q) ? terr_pkg::ST_R_LOAD : terr_pkg::ST_DONE;
			end
			terr_pkg::ST_R_LOAD: state_d = terr_pkg::ST_R_LWAIT;
			terr_pkg::ST_R_LWAIT: begin
				if ((rd_lx >= rd_ux) || (rd_ly >= rd_uy)) begin
					state_d = terr_pkg::ST_MEAN;
				end else begin
					state_d = terr_pkg::ST_S_ISSUE;
				end
			end
			terr_pkg::ST_S_ISSUE: state_d = terr_pkg::ST_S_USE;
			terr_pkg::ST_S_USE: begin
				if (scan_last) begin
					state_d = (rmax_nx > thr_q) ? terr_pkg::ST_RAISE_ISSUE : terr_pkg::ST_MEAN;
				end else begin
					state_d = terr_pkg::ST_S_ISSUE;
				end
			end
			terr_pkg::ST_RAISE_ISSUE: state_d = terr_pkg::ST_RAISE_USE;
			terr_pkg::ST_RAISE_USE: begin
				err_we  = (err_rdata < min_err_q);
				state_d = scan_last ? terr_pkg::ST_MEAN : terr_pkg::ST_RAISE_ISSUE;
			end
			terr_pkg::ST_MEAN: begin
				if ((area_w != '0) && (rsum_q != terr_pkg::ERR_INF)) begin
					state_d = terr_pkg::ST_DIV;
				end else begin
					state_d = terr_pkg::ST_DECIDE;
				end
			end
			terr_pkg::ST_DECIDE: begin
				if (mean_q <= lim4_q) begin
					if ((area_q <= PW'(2)) || (rmax_q <= thr_q)) begin
						state_d = terr_pkg::ST_RM_RD_A;
					end else if (32'(count_q) >= MAX_REGIONS) begin
						state_d = terr_pkg::ST_R_CHECK;
					end else begin
						state_d = terr_pkg::ST_SPLIT_A;
					end
				end else begin
					state_d = terr_pkg::ST_R_CHECK;
				end
			end
			terr_pkg::ST_RM_RD_A: begin
				rgn_ra  = regions_q[RW-1:0];
				state_d = terr_pkg::ST_RM_RD_B;
			end
			terr_pkg::ST_RM_RD_B: begin
				rgn_ra  = cnt_m1[RW-1:0];
				state_d = terr_pkg::ST_RM_WR_A;
			end
			terr_pkg::ST_RM_WR_A: begin
				rgn_we  = 1'b1;
				rgn_wa  = i_q[RW-1:0];
				rgn_wd  = rgn_a_q;
				state_d = terr_pkg::ST_RM_WR_B;
			end
			terr_pkg::ST_RM_WR_B: begin
				rgn_we  = 1'b1;
				rgn_wa  = regions_q[RW-1:0];
				rgn_wd  = rgn_b_q;
				state_d = terr_pkg::ST_R_CHECK;
			end
			terr_pkg::ST_SPLIT_A: begin
				rgn_we  = 1'b1;
				rgn_wa  = i_q[RW-1:0];
				rgn_wd  = split_x ? {lx_q, ly_q, mid_x, uy_q} : {lx_q, ly_q, ux_q, mid_y};
				state_d = terr_pkg::ST_SPLIT_B;
			end
			terr_pkg::ST_SPLIT_B: begin
				rgn_we  = 1'b1;
				rgn_wa  = count_q[RW-1:0];
				rgn_wd  = split_x ? {mid_x, ly_q, ux_q, uy_q} : {lx_q, mid_y, ux_q, uy_q};
				state_d = terr_pkg::ST_R_CHECK;
			end
			terr_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = terr_pkg::ST_IDLE;
				end
			end
			default: state_d = terr_pkg::ST_IDLE;
		endcase
	end

	// Control registers: grid size, clearing pass and region count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= 5'd16;
			gh_q    <= 5'd16;
			sweep_q <= '0;
			reply_q <= 1'b0;
			count_q <= CNTW'(1);
		end else if (cfg_we) begin
			if (paddr[2] == terr_pkg::REG_GRID_H) begin
				gh_q <= pwdata[4:0];
			end else begin
				gw_q <= pwdata[4:0];
			end
			sweep_q <= '0;
			reply_q <= 1'b0;
			count_q <= CNTW'(1);
		end else begin
			case (state_q)
				terr_pkg::ST_SWEEP: sweep_q <= sweep_q + 1'b1;
				terr_pkg::ST_IDLE: begin
					if (in_acc && (terr_pkg::func_t'(func) == terr_pkg::FN_CLEAR)) begin
						sweep_q <= '0;
						reply_q <= 1'b1;
						count_q <= CNTW'(1);
					end
				end
				terr_pkg::ST_RM_WR_B: count_q <= count_q - 1'b1;
				terr_pkg::ST_SPLIT_B: count_q <= count_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			terr_pkg::ST_IDLE: begin
				if (in_acc) begin
					thr_q       <= threshold;
					lim4_q      <= lim4_in;
					min_err_q   <= min_err_in;
					maxv_q      <= '0;
					sum_q       <= '0;
					act_q       <= '0;
					ti_q        <= '0;
					res_tile_q  <= '0;
					res_frame_q <= '0;
					if ((terr_pkg::func_t'(func) == terr_pkg::FN_READ) && !in_inside) begin
						res_tile_q <= terr_pkg::ERR_INF;
					end
					if ((terr_pkg::func_t'(func) == terr_pkg::FN_REFINE) && (tiles == '0)) begin
						res_frame_q <= terr_pkg::ERR_INF;
					end
				end
			end
			terr_pkg::ST_RD_WAIT: res_tile_q <= err_rdata;
			terr_pkg::ST_F_USE: begin
				if (err_rdata > maxv_q) begin
					maxv_q <= err_rdata;
				end
				if (err_rdata > thr_q) begin
					sum_q <= fsum_sat;
					act_q <= act_q + 1'b1;
				end
				ti_q <= ti_q + 1'b1;
			end
			terr_pkg::ST_F_END: begin
				if (act_q == '0) begin
					res_frame_q <= maxv_q;
				end else if (sum_q == terr_pkg::ERR_INF) begin
					res_frame_q <= terr_pkg::ERR_INF;
				end else begin
					div_rem_q   <= '0;
					div_quo_q   <= sum_q;
					div_den_q   <= 32'(act_q);
					div_cnt_q   <= '0;
					div_frame_q <= 1'b1;
				end
			end
			terr_pkg::ST_POST: begin
				regions_q <= count_q;
				i_q       <= '0;
			end
			terr_pkg::ST_DIV: begin
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == 5'd31) begin
					if (div_frame_q) begin
						res_frame_q <= div_quo_nx;
					end else begin
						mean_q <= div_quo_nx;
					end
				end
			end
			terr_pkg::ST_R_LWAIT: begin
				lx_q   <= rd_lx;
				ly_q   <= rd_ly;
				ux_q   <= rd_ux;
				uy_q   <= rd_uy;
				x_q    <= rd_lx;
				y_q    <= rd_ly;
				rsum_q <= '0;
				rmax_q <= '0;
			end
			terr_pkg::ST_S_USE: begin
				rsum_q <= rsum_sat;
				rmax_q <= rmax_nx;
				if (scan_last) begin
					x_q <= lx_q;
					y_q <= ly_q;
				end else if (x_end) begin
					x_q <= lx_q;
					y_q <= y_nx;
				end else begin
					x_q <= x_nx;
				end
			end
			terr_pkg::ST_RAISE_USE: begin
				if (x_end) begin
					x_q <= lx_q;
					y_q <= y_nx;
				end else begin
					x_q <= x_nx;
				end
			end
			terr_pkg::ST_MEAN: begin
				area_q <= area_w;
				if (area_w == '0) begin
					mean_q <= '0;
				end else if (rsum_q == terr_pkg::ERR_INF) begin
					mean_q <= terr_pkg::ERR_INF;
				end else begin
					div_rem_q   <= '0;
					div_quo_q   <= rsum_q;
					div_den_q   <= 32'(area_w);
					div_cnt_q   <= '0;
					div_frame_q <= 1'b0;
				end
			end
			terr_pkg::ST_DECIDE: begin
				if (mean_q <= lim4_q) begin
					if ((area_q <= PW'(2)) || (rmax_q <= thr_q)) begin
						regions_q <= regions_q - 1'b1;
					end else if (32'(count_q) >= MAX_REGIONS) begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			terr_pkg::ST_RM_RD_B: rgn_a_q <= rgn_rdata;
			terr_pkg::ST_RM_WR_A: rgn_b_q <= rgn_rdata;
			terr_pkg::ST_SPLIT_B: i_q <= i_q + 1'b1;
			default: ;
		endcase
	end

	// Output register: holds a result until the receiver takes it.
	logic [31:0] cnt_ext;
	assign cnt_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == terr_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == terr_pkg::ST_DONE) && out_free) begin
			tile_error_q   <= res_tile_q;
			frame_error_q  <= res_frame_q;
			region_total_q <= cnt_ext[8:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign tile_error   = tile_error_q;
	assign frame_error  = frame_error_q;
	assign region_total = region_total_q;

endmodule
